FILE: rtl/nspd_pkg.sv
// Shared constants, types and the CORDIC angle table of the N-step phase
// shift demodulator. No dependencies.
`default_nettype none
package nspd_pkg;

    localparam int MAX_PIXELS_DEF  = 65536;
    localparam int MAX_STEPS_DEF   = 16;
    localparam int SAMPLE_BITS_DEF = 16;

    localparam int STEPS_W    = 5;
    localparam int PCOUNT_W   = 17;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 17;

    localparam int COEF_W       = 16;
    localparam int CORDIC_ITERS = 20;
    localparam int ITER_W       = 5;
    localparam int ANG_W        = 34;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_STEPS       = 1'b0,
        REG_PIXEL_COUNT = 1'b1
    } cfg_reg_t;

    typedef logic signed [ANG_W-1:0] angle_t;

    localparam angle_t ANGLE_PI   = 34'sh080000000;
    localparam angle_t HALF_PI    = 34'sh040000000;
    localparam angle_t TWO_PI     = 34'sh100000000;
    localparam angle_t KINV_Q30   = 34'sd652032874;
    localparam logic [23:0] KINV_Q24 = 24'd10188013;

    localparam angle_t ATAN_TABLE [CORDIC_ITERS] = '{
        34'sh20000000, 34'sh12E4051E, 34'sh09FB385B, 34'sh051111D4, 34'sh028B0D43,
        34'sh0145D7E1, 34'sh00A2F61E, 34'sh00517C55, 34'sh0028BE53, 34'sh00145F2F,
        34'sh000A2F98, 34'sh000517CC, 34'sh00028BE6, 34'sh000145F3, 34'sh0000A2FA,
        34'sh0000517D, 34'sh000028BE, 34'sh0000145F, 34'sh00000A30, 34'sh00000518
    };

    typedef struct packed {
        logic busy;
        logic done;
    } unit_status_t;

endpackage
`default_nettype wire

FILE: rtl/nspd_ram.sv
// Generic single-clock RAM, one write and one read port, registered read.
// No dependencies.
`default_nettype none
module nspd_ram #(
    parameter int WIDTH = 36,
    parameter int DEPTH = 65536
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

FILE: rtl/nspd_coef.sv
// Coefficient sequencer: sin and cos of 2*pi*k/n in Q1.15 through k mod n,
// a restoring angle divide and a CORDIC rotation. Depends on nspd_pkg.
`default_nettype none
module nspd_coef #(
    parameter int MAX_STEPS = 16
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic [$clog2(MAX_STEPS)-1:0]     k,
    input  wire logic [$clog2(MAX_STEPS+1)-1:0]   n,
    output logic signed [nspd_pkg::COEF_W-1:0]    sin_q15,
    output logic signed [nspd_pkg::COEF_W-1:0]    cos_q15,
    output nspd_pkg::unit_status_t                status
);
    import nspd_pkg::*;

    localparam int FC_W  = $clog2(MAX_STEPS);
    localparam int N_W   = $clog2(MAX_STEPS+1);
    localparam int NUM_W = FC_W + 32;
    localparam int CNT_W = $clog2(NUM_W+1);

    typedef enum logic [2:0] {C_IDLE, C_MOD, C_DIV, C_ROT, C_FIN} cstate_t;

    cstate_t state_reg;
    logic [FC_W-1:0]  key_k_reg;
    logic [N_W-1:0]   key_n_reg;
    logic             valid_reg;
    logic [N_W-1:0]   kk_reg;
    logic [NUM_W-1:0] num_reg;
    logic [N_W-1:0]   rem_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [ITER_W-1:0] iter_reg;
    angle_t x_reg, y_reg, z_reg;
    logic neg_reg;
    logic signed [COEF_W-1:0] sin_reg, cos_reg;

    function automatic logic signed [COEF_W-1:0] to_q15(input angle_t v);
        logic signed [ANG_W:0] t;
        logic signed [ANG_W:0] r;
        t = {v[ANG_W-1], v} + 35'sd16384;
        r = t >>> 15;
        if (r > 35'sd32767)
            return 16'sh7FFF;
        else if (r < -35'sd32768)
            return 16'sh8000;
        return r[COEF_W-1:0];
    endfunction

    logic ready;
    logic [N_W:0] rem_sh, rem_sub;
    logic ge;
    angle_t zs, zf, dx, dy;
    logic nf;

    assign ready = valid_reg && (key_k_reg == k) && (key_n_reg == n) && (state_reg == C_IDLE);

    always_comb
    begin
        rem_sh  = {rem_reg, num_reg[NUM_W-1]};
        ge      = rem_sh >= {1'b0, key_n_reg};
        rem_sub = rem_sh - {1'b0, key_n_reg};
        zs = {2'b00, num_reg[31:0]};
        if (zs > ANGLE_PI)
            zs = zs - TWO_PI;
        zf = zs;
        nf = 1'b0;
        if (zs > HALF_PI)
        begin
            zf = zs - ANGLE_PI;
            nf = 1'b1;
        end
        else if (zs < -HALF_PI)
        begin
            zf = zs + ANGLE_PI;
            nf = 1'b1;
        end
        dx = y_reg >>> iter_reg;
        dy = x_reg >>> iter_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= C_IDLE;
            valid_reg <= 1'b0;
            key_k_reg <= '0;
            key_n_reg <= '0;
        end
        else
        begin
            case (state_reg)
                C_IDLE:
                begin
                    if (!ready)
                    begin
                        valid_reg <= 1'b0;
                        key_k_reg <= k;
                        key_n_reg <= n;
                        kk_reg    <= N_W'(k);
                        state_reg <= C_MOD;
                    end
                end
                C_MOD:
                begin
                    if (kk_reg >= key_n_reg)
                    begin
                        kk_reg <= kk_reg - key_n_reg;
                    end
                    else
                    begin
                        num_reg   <= {kk_reg[FC_W-1:0], 32'b0} + NUM_W'(key_n_reg >> 1);
                        rem_reg   <= '0;
                        cnt_reg   <= '0;
                        state_reg <= C_DIV;
                    end
                end
                C_DIV:
                begin
                    rem_reg <= ge ? rem_sub[N_W-1:0] : rem_sh[N_W-1:0];
                    num_reg <= {num_reg[NUM_W-2:0], ge};
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == CNT_W'(NUM_W-1))
                    begin
                        state_reg <= C_ROT;
                        iter_reg  <= '0;
                        x_reg     <= KINV_Q30;
                        y_reg     <= '0;
                    end
                end
                C_ROT:
                begin
                    if (iter_reg == '0 && cnt_reg == CNT_W'(NUM_W))
                    begin
                        z_reg   <= zf;
                        neg_reg <= nf;
                        cnt_reg <= '0;
                    end
                    else
                    begin
                        if (z_reg >= 0)
                        begin
                            x_reg <= x_reg - dx;
                            y_reg <= y_reg + dy;
                            z_reg <= z_reg - ATAN_TABLE[iter_reg];
                        end
                        else
                        begin
                            x_reg <= x_reg + dx;
                            y_reg <= y_reg - dy;
                            z_reg <= z_reg + ATAN_TABLE[iter_reg];
                        end
                        iter_reg <= iter_reg + 1'b1;
                        if (iter_reg == ITER_W'(CORDIC_ITERS-1))
                            state_reg <= C_FIN;
                    end
                end
                C_FIN:
                begin
                    sin_reg   <= to_q15(neg_reg ? -y_reg : y_reg);
                    cos_reg   <= to_q15(neg_reg ? -x_reg : x_reg);
                    valid_reg <= 1'b1;
                    state_reg <= C_IDLE;
                end
                default:
                begin
                    state_reg <= C_IDLE;
                end
            endcase
        end
    end

    assign sin_q15     = sin_reg;
    assign cos_q15     = cos_reg;
    assign status.done = ready;
    assign status.busy = (state_reg != C_IDLE);
endmodule
`default_nettype wire

FILE: rtl/nspd_demod.sv
// Demodulation unit: CORDIC vectoring of (C, -S) to phase and magnitude,
// split multiply by the inverse CORDIC gain, restoring divide by N. Depends on nspd_pkg.
`default_nettype none
module nspd_demod #(
    parameter int SUM_W = 36,
    parameter int N_W   = 5
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         start,
    input  wire logic                         take,
    input  wire logic signed [SUM_W-1:0]      s_sum,
    input  wire logic signed [SUM_W-1:0]      c_sum,
    input  wire logic [N_W-1:0]               n,
    output logic [15:0]                       phase,
    output logic [15:0]                       modulation,
    output nspd_pkg::unit_status_t            status
);
    import nspd_pkg::*;

    localparam int W     = SUM_W + 3;
    localparam int XU_W  = W - 1;
    localparam int LO_W  = XU_W / 2;
    localparam int HI_W  = XU_W - LO_W;
    localparam int P_W   = XU_W + 24;
    localparam int SP_W  = ((P_W > N_W + 37) ? P_W : N_W + 37) + 1;
    localparam int T_W   = SP_W - 38;
    localparam int QX_W  = (T_W > 17) ? T_W : 17;
    localparam int DC_W  = $clog2(T_W+1);

    typedef logic signed [W-1:0] vec_t;
    typedef enum logic [2:0] {D_IDLE, D_ROT, D_MUL0, D_MUL1, D_DIV, D_DONE} dstate_t;

    dstate_t state_reg;
    vec_t x_reg, y_reg;
    angle_t z_reg;
    logic [ITER_W-1:0] iter_reg;
    logic [N_W-1:0] n_reg;
    logic [LO_W+23:0] lo_reg;
    logic [HI_W-1:0]  hi_reg;
    logic [T_W-1:0]   t_reg;
    logic [N_W-1:0]   rem_reg;
    logic [DC_W-1:0]  cnt_reg;
    logic [15:0] phase_reg, mod_reg;

    vec_t cx, cy, dx, dy;
    angle_t zr;
    logic [XU_W-1:0] xp;
    logic [LO_W+23:0] lo_prod;
    logic [HI_W+23:0] hi_prod;
    logic [SP_W-1:0] sp;
    logic [N_W:0] rem_sh, rem_sub;
    logic ge;
    logic [T_W-1:0] q_next;
    logic [QX_W-1:0] qx;

    always_comb
    begin
        cx = vec_t'(c_sum);
        cy = -vec_t'(s_sum);
        dx = y_reg >>> iter_reg;
        dy = x_reg >>> iter_reg;
        zr = z_reg + 34'sd32768;
        xp = x_reg[W-1] ? '0 : x_reg[XU_W-1:0];
        lo_prod = xp[LO_W-1:0] * KINV_Q24;
        hi_prod = hi_reg * KINV_Q24;
        sp = ((SP_W'(hi_prod) << LO_W) + SP_W'(lo_reg)) + (SP_W'(n_reg) << 37);
        rem_sh  = {rem_reg, t_reg[T_W-1]};
        ge      = rem_sh >= {1'b0, n_reg};
        rem_sub = rem_sh - {1'b0, n_reg};
        q_next  = {t_reg[T_W-2:0], ge};
        qx      = QX_W'(q_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= D_IDLE;
        end
        else
        begin
            case (state_reg)
                D_IDLE:
                begin
                    if (start)
                    begin
                        n_reg    <= n;
                        iter_reg <= '0;
                        if (c_sum == '0 && s_sum == '0)
                        begin
                            phase_reg <= '0;
                            mod_reg   <= '0;
                            state_reg <= D_DONE;
                        end
                        else
                        begin
                            if (cx < 0)
                            begin
                                z_reg <= (cy >= 0) ? ANGLE_PI : -ANGLE_PI;
                                x_reg <= -cx;
                                y_reg <= -cy;
                            end
                            else
                            begin
                                z_reg <= '0;
                                x_reg <= cx;
                                y_reg <= cy;
                            end
                            state_reg <= D_ROT;
                        end
                    end
                end
                D_ROT:
                begin
                    if (y_reg > 0)
                    begin
                        x_reg <= x_reg + dx;
                        y_reg <= y_reg - dy;
                        z_reg <= z_reg + ATAN_TABLE[iter_reg];
                    end
                    else
                    begin
                        x_reg <= x_reg - dx;
                        y_reg <= y_reg + dy;
                        z_reg <= z_reg - ATAN_TABLE[iter_reg];
                    end
                    iter_reg <= iter_reg + 1'b1;
                    if (iter_reg == ITER_W'(CORDIC_ITERS-1))
                        state_reg <= D_MUL0;
                end
                D_MUL0:
                begin
                    phase_reg <= zr[31:16];
                    lo_reg    <= lo_prod;
                    hi_reg    <= xp[XU_W-1:LO_W];
                    state_reg <= D_MUL1;
                end
                D_MUL1:
                begin
                    t_reg     <= sp[SP_W-1:38];
                    rem_reg   <= '0;
                    cnt_reg   <= '0;
                    state_reg <= D_DIV;
                end
                D_DIV:
                begin
                    rem_reg <= ge ? rem_sub[N_W-1:0] : rem_sh[N_W-1:0];
                    t_reg   <= q_next;
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == DC_W'(T_W-1))
                    begin
                        mod_reg   <= (qx > QX_W'(65535)) ? 16'hFFFF : qx[15:0];
                        state_reg <= D_DONE;
                    end
                end
                D_DONE:
                begin
                    if (take)
                        state_reg <= D_IDLE;
                end
                default:
                begin
                    state_reg <= D_IDLE;
                end
            endcase
        end
    end

    assign phase       = phase_reg;
    assign modulation  = mod_reg;
    assign status.done = (state_reg == D_DONE);
    assign status.busy = (state_reg != D_IDLE) && (state_reg != D_DONE);
endmodule
`default_nettype wire

FILE: rtl/n_step_phase_shift_demodulator.sv
// Top level of the N-step phase shift demodulator: counters, sum memories,
// accumulate step and output register. Depends on nspd_pkg, nspd_ram,
// nspd_coef and nspd_demod.
//
// Frames of one set arrive pixel after pixel; each pixel's sine and cosine
// sums live in two RAMs of MAX_PIXELS entries (read, add, write back). On a
// frame other than the last an item passes a RAM read and an accumulate
// step. On the last frame the demod unit then runs 20 CORDIC vectoring
// iterations, a split multiply (D_MUL0, D_MUL1) and a restoring divide by
// N over T = 25 bits at default widths, then the result waits in an output
// register while the next item is taken. At the first item of each frame,
// and after a write that changes the effective steps, the coefficient
// sequencer runs (k mod N, a 36-step angle divide, 20 rotations) while
// input stalls. The sum RAMs have no clearing pass.
`default_nettype none
module n_step_phase_shift_demodulator #(
    parameter int MAX_PIXELS  = nspd_pkg::MAX_PIXELS_DEF,
    parameter int MAX_STEPS   = nspd_pkg::MAX_STEPS_DEF,
    parameter int SAMPLE_BITS = nspd_pkg::SAMPLE_BITS_DEF
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_write,
    input  wire logic [nspd_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [nspd_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  wire logic                              in_valid,
    output logic                                   in_stall,
    input  wire logic [15:0]                       intensity,
    output logic                                   out_valid,
    input  wire logic                              out_stall,
    output logic signed [15:0]                     phase,
    output logic [15:0]                            modulation,
    output logic [15:0]                            pixel_position,
    output logic                                   last_pixel
);
    import nspd_pkg::*;

    localparam int PIX_W = $clog2(MAX_PIXELS);
    localparam int NP_W  = $clog2(MAX_PIXELS+1);
    localparam int FC_W  = $clog2(MAX_STEPS);
    localparam int N_W   = $clog2(MAX_STEPS+1);
    localparam int SUM_W = SAMPLE_BITS + COEF_W + $clog2(MAX_STEPS);
    localparam int PR_W  = SAMPLE_BITS + 1 + COEF_W;

    typedef enum logic [1:0] {S_IDLE, S_ACC, S_DEMOD} state_t;

    state_t state_reg;
    logic [STEPS_W-1:0]  steps_reg;
    logic [PCOUNT_W-1:0] pixel_count_reg;
    logic [PIX_W-1:0]    pixel_counter_reg;
    logic [FC_W-1:0]     frame_counter_reg;
    logic [SAMPLE_BITS-1:0] inten_reg;
    logic [PIX_W-1:0]    pos_reg;
    logic first_reg, lastf_reg, lastp_reg;
    logic signed [COEF_W-1:0] sin_reg, cos_reg;
    logic out_valid_reg;
    logic [15:0] out_phase_reg, out_mod_reg, out_pos_reg;
    logic out_last_reg;

    logic [N_W-1:0]  n_eff;
    logic [NP_W-1:0] np_eff;
    logic last_frame, last_pix, accept, load_out;
    logic signed [COEF_W-1:0] coef_sin, coef_cos;
    unit_status_t coef_status, dmd_status;
    logic [SUM_W-1:0] s_rd, c_rd;
    logic signed [PR_W-1:0] prod_s, prod_c;
    logic signed [SUM_W-1:0] s_new, c_new;
    logic [15:0] dmd_phase, dmd_mod;
    logic acc_we, dmd_start;

    always_comb
    begin
        if (steps_reg < STEPS_W'(3))
            n_eff = N_W'(3);
        else if (int'(steps_reg) > MAX_STEPS)
            n_eff = N_W'(MAX_STEPS);
        else
            n_eff = N_W'(steps_reg);
        if (pixel_count_reg == '0)
            np_eff = NP_W'(1);
        else if (int'(pixel_count_reg) > MAX_PIXELS)
            np_eff = NP_W'(MAX_PIXELS);
        else
            np_eff = NP_W'(pixel_count_reg);
        last_frame = ((N_W+1)'(frame_counter_reg) + 1'b1) >= (N_W+1)'(n_eff);
        last_pix   = ((NP_W+1)'(pixel_counter_reg) + 1'b1) >= (NP_W+1)'(np_eff);
        prod_s = signed'({1'b0, inten_reg}) * sin_reg;
        prod_c = signed'({1'b0, inten_reg}) * cos_reg;
        s_new  = (first_reg ? '0 : signed'(s_rd)) + SUM_W'(prod_s);
        c_new  = (first_reg ? '0 : signed'(c_rd)) + SUM_W'(prod_c);
    end

    assign in_stall  = !((state_reg == S_IDLE) && coef_status.done);
    assign accept    = in_valid && !in_stall;
    assign acc_we    = (state_reg == S_ACC);
    assign dmd_start = acc_we && lastf_reg;
    assign load_out  = (state_reg == S_DEMOD) && dmd_status.done
                       && (!out_valid_reg || !out_stall);

    nspd_ram #(.WIDTH(SUM_W), .DEPTH(MAX_PIXELS)) u_sine_ram (
        .clk   (clk),
        .we    (acc_we),
        .waddr (pos_reg),
        .wdata (s_new),
        .raddr (pixel_counter_reg),
        .rdata (s_rd)
    );

    nspd_ram #(.WIDTH(SUM_W), .DEPTH(MAX_PIXELS)) u_cosine_ram (
        .clk   (clk),
        .we    (acc_we),
        .waddr (pos_reg),
        .wdata (c_new),
        .raddr (pixel_counter_reg),
        .rdata (c_rd)
    );

    nspd_coef #(.MAX_STEPS(MAX_STEPS)) u_coef (
        .clk     (clk),
        .rst_n   (rst_n),
        .k       (frame_counter_reg),
        .n       (n_eff),
        .sin_q15 (coef_sin),
        .cos_q15 (coef_cos),
        .status  (coef_status)
    );

    nspd_demod #(.SUM_W(SUM_W), .N_W(N_W)) u_demod (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (dmd_start),
        .take       (load_out),
        .s_sum      (s_new),
        .c_sum      (c_new),
        .n          (n_eff),
        .phase      (dmd_phase),
        .modulation (dmd_mod),
        .status     (dmd_status)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= S_IDLE;
            steps_reg         <= STEPS_W'(4);
            pixel_count_reg   <= PCOUNT_W'(65536);
            pixel_counter_reg <= '0;
            frame_counter_reg <= '0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_index)
                    REG_STEPS:       steps_reg       <= cfg_data[STEPS_W-1:0];
                    REG_PIXEL_COUNT: pixel_count_reg <= cfg_data[PCOUNT_W-1:0];
                    default:         steps_reg       <= steps_reg;
                endcase
            end
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
                out_phase_reg <= dmd_phase;
                out_mod_reg   <= dmd_mod;
                out_pos_reg   <= 16'(pos_reg);
                out_last_reg  <= lastp_reg;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        inten_reg <= intensity[SAMPLE_BITS-1:0];
                        pos_reg   <= pixel_counter_reg;
                        first_reg <= (frame_counter_reg == '0);
                        lastf_reg <= last_frame;
                        lastp_reg <= last_pix;
                        sin_reg   <= coef_sin;
                        cos_reg   <= coef_cos;
                        if (last_pix)
                        begin
                            pixel_counter_reg <= '0;
                            frame_counter_reg <= last_frame ? '0
                                                 : FC_W'(frame_counter_reg + 1'b1);
                        end
                        else
                        begin
                            pixel_counter_reg <= PIX_W'(pixel_counter_reg + 1'b1);
                        end
                        state_reg <= S_ACC;
                    end
                end
                S_ACC:
                begin
                    state_reg <= lastf_reg ? S_DEMOD : S_IDLE;
                end
                S_DEMOD:
                begin
                    if (load_out)
                        state_reg <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign out_valid      = out_valid_reg;
    assign phase          = signed'(out_phase_reg);
    assign modulation     = out_mod_reg;
    assign pixel_position = out_pos_reg;
    assign last_pixel     = out_last_reg;

    a_acc_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_ACC) |-> $past(accept))
        else $error("accumulate step without an accepted item");

    a_idle_demod_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> !dmd_status.busy)
        else $error("demod unit busy while top level idle");

    a_accept_coef_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> !coef_status.busy)
        else $error("item taken while coefficients recompute");

    a_result_last_frame: assert property (@(posedge clk) disable iff (!rst_n)
        load_out |-> lastf_reg)
        else $error("result loaded for an item outside the last frame");
endmodule
`default_nettype wire
